// File: rtl/ksld_pkg.sv
// Package with the shared types, key codes and display constants of the setpoint LCD block.
`default_nettype none
package ksld_pkg;

    // Widths of the payload fields and internal counters.
    localparam int unsigned VAL_W  = 14;
    localparam int unsigned KEY_W  = 4;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 5;
    localparam int unsigned DIG_W  = 4;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [VAL_W-1:0]  value_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [BYTE_W-1:0] lcd_byte_t;
    typedef logic [DIG_W-1:0]  digit_t;

    // Active-low key patterns.
    localparam logic [KEY_W-1:0] KEY_SHOW  = 4'hE;
    localparam logic [KEY_W-1:0] KEY_UP    = 4'hD;
    localparam logic [KEY_W-1:0] KEY_DOWN  = 4'hB;
    localparam logic [KEY_W-1:0] KEY_CLEAR = 4'h7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 2'd1;

    localparam value_t UPPER_LIMIT_RST = 14'd5000;
    localparam value_t LOWER_LIMIT_RST = 14'd1;
    localparam value_t DISPLAY_MAX     = 14'd9999;

    // LCD commands that set the cursor address.
    localparam lcd_byte_t CMD_LABEL = 8'h80;
    localparam lcd_byte_t CMD_UNIT  = 8'h8C;
    localparam lcd_byte_t CMD_VALUE = 8'h88;
    localparam lcd_byte_t ASCII_ZERO = 8'h30;

    // Positions within the full redraw sequence.
    localparam idx_t IDX_LABEL_CMD = 5'd0;
    localparam idx_t IDX_UNIT_CMD  = 5'd9;
    localparam idx_t IDX_VALUE_CMD = 5'd13;
    localparam idx_t IDX_THOUSANDS = 5'd14;
    localparam idx_t IDX_HUNDREDS  = 5'd15;
    localparam idx_t IDX_TENS      = 5'd16;
    localparam idx_t IDX_LAST      = 5'd17;

    // One output beat as produced by the byte generator.
    typedef struct packed {
        lcd_byte_t lcd_byte;
        logic      is_data;
        logic      last_byte;
    } beat_t;

    // Fixed text of the redraw sequence, positions 0 to 13.
    function automatic lcd_byte_t text_byte(input idx_t idx);
        lcd_byte_t b;
        case (idx)
            5'd0:    b = CMD_LABEL;
            5'd1:    b = 8'h53; // S
            5'd2:    b = 8'h45; // E
            5'd3:    b = 8'h54; // T
            5'd4:    b = 8'h20;
            5'd5:    b = 8'h53; // S
            5'd6:    b = 8'h50; // P
            5'd7:    b = 8'h44; // D
            5'd8:    b = 8'h3A; // :
            5'd9:    b = CMD_UNIT;
            5'd10:   b = 8'h72; // r
            5'd11:   b = 8'h70; // p
            5'd12:   b = 8'h6D; // m
            default: b = CMD_VALUE;
        endcase
        return b;
    endfunction

    // Decimal weight of the digit emitted at a position.
    function automatic value_t digit_weight(input idx_t idx);
        value_t w;
        case (idx)
            IDX_THOUSANDS: w = 14'd1000;
            IDX_HUNDREDS:  w = 14'd100;
            IDX_TENS:      w = 14'd10;
            default:       w = 14'd1;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ksld_byte_gen.sv
// Byte generator: the LCD byte at one sequence position and one decimal digit step.
`default_nettype none
module ksld_byte_gen (
    input  wire ksld_pkg::idx_t   idx,
    input  wire ksld_pkg::value_t rem,
    output ksld_pkg::beat_t       beat,
    output ksld_pkg::value_t      rem_next
);

    ksld_pkg::value_t weight;
    ksld_pkg::digit_t digit;
    logic             is_digit;

    // Digit by comparing the remainder against the nine multiples of its weight.
    always_comb
    begin
        weight = ksld_pkg::digit_weight(idx);
        digit  = '0;
        for (int k = 1; k < 10; k++)
        begin
            if ({4'd0, rem} >= 18'(k) * {4'd0, weight})
            begin
                digit = ksld_pkg::digit_t'(k);
            end
        end
    end

    assign is_digit = (idx >= ksld_pkg::IDX_THOUSANDS);

    // Remove the emitted digit so the next position sees the lower places.
    assign rem_next = is_digit
                    ? ksld_pkg::value_t'(rem - ksld_pkg::value_t'({10'd0, digit} * weight))
                    : rem;

    // Select text or digit and flag the command positions.
    always_comb
    begin
        beat.lcd_byte  = is_digit ? (ksld_pkg::ASCII_ZERO | {4'd0, digit})
                                  : ksld_pkg::text_byte(idx);
        beat.is_data   = !(idx == ksld_pkg::IDX_LABEL_CMD || idx == ksld_pkg::IDX_UNIT_CMD
                           || idx == ksld_pkg::IDX_VALUE_CMD);
        beat.last_byte = (idx == ksld_pkg::IDX_LAST);
    end

endmodule
`default_nettype wire

// File: rtl/key_setpoint_lcd_display.sv
// Top level: key-driven speed setpoint with a character-LCD byte stream output.
//
// The slave channel takes one active-low key sample per beat. A show key
// yields an 18-beat redraw (label, unit, then the value); up, down and clear
// change the setpoint at acceptance and yield a 5-beat value rewrite. Other
// patterns are accepted and dropped with no output and no state change.
// The master channel carries one LCD byte per beat, tuser set for character
// data and tlast on the final byte of a key's sequence.
// A key is registered in the key buffer, then loaded into the emitter, and
// each byte is registered in the output register. Unless the receiver
// stalls, bytes leave at one per cycle, set by the single byte emitter, which
// walks the sequence one position per cycle and works out one decimal digit
// per step. A one-entry key buffer takes the next key while the emitter is
// busy, and the next sequence follows the previous one back to back. When the
// receiver stalls, the output register holds its beat, the emitter waits, and
// tready drops once the key buffer is full. Reset clears the setpoint to zero,
// sets the limits to 5000 and 1 and empties the buffer, emitter and output
// register. Limit registers are written through wr_en, wr_index and wr_data;
// the user must do so only while idle, which the block does not enforce.
`default_nettype none
module key_setpoint_lcd_display (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        wr_en,
    input  wire [1:0]  wr_index,
    input  wire [13:0] wr_data,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,   // [3:0] key_bits, [7:4] zero
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [7:0] lcd_byte
    output logic       m_tuser,   // [0] is_data
    output logic       m_tlast
);

    ksld_pkg::value_t upper_limit_reg;
    ksld_pkg::value_t lower_limit_reg;
    ksld_pkg::value_t setpoint_reg;
    ksld_pkg::value_t setpoint_next;

    logic             pend_valid_reg;
    ksld_pkg::idx_t   pend_start_reg;
    ksld_pkg::value_t pend_value_reg;

    logic             act_reg;
    ksld_pkg::idx_t   idx_reg;
    ksld_pkg::value_t rem_reg;

    ksld_pkg::beat_t  beat;
    ksld_pkg::value_t gen_rem_next;

    logic [3:0] key;
    logic       key_known;
    logic       in_take;
    logic       out_free;
    logic       step;
    logic       fin;
    logic       load;

    assign key      = s_tdata[3:0];
    assign s_tready = !pend_valid_reg;
    assign in_take  = s_tvalid && s_tready;

    // Setpoint update rules per key.
    always_comb
    begin
        key_known     = 1'b1;
        setpoint_next = setpoint_reg;
        case (key)
            ksld_pkg::KEY_SHOW:
            begin
                setpoint_next = setpoint_reg;
            end
            ksld_pkg::KEY_UP:
            begin
                if (setpoint_reg >= upper_limit_reg)
                    setpoint_next = upper_limit_reg;
                else
                    setpoint_next = setpoint_reg + 14'd1;
            end
            ksld_pkg::KEY_DOWN:
            begin
                if (setpoint_reg <= lower_limit_reg)
                    setpoint_next = lower_limit_reg;
                else
                    setpoint_next = setpoint_reg - 14'd1;
            end
            ksld_pkg::KEY_CLEAR:
            begin
                setpoint_next = '0;
            end
            default:
            begin
                key_known = 1'b0;
            end
        endcase
    end

    // Limit registers and the setpoint.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_limit_reg <= ksld_pkg::UPPER_LIMIT_RST;
            lower_limit_reg <= ksld_pkg::LOWER_LIMIT_RST;
            setpoint_reg    <= '0;
        end
        else
        begin
            if (wr_en && wr_index == ksld_pkg::REG_UPPER_LIMIT)
                upper_limit_reg <= wr_data;
            if (wr_en && wr_index == ksld_pkg::REG_LOWER_LIMIT)
                lower_limit_reg <= wr_data;
            if (in_take && key_known)
                setpoint_reg <= setpoint_next;
        end
    end

    // Emitter control.
    assign out_free = !m_tvalid || m_tready;
    assign step     = act_reg && out_free;
    assign fin      = step && beat.last_byte;
    assign load     = pend_valid_reg && (!act_reg || fin);

    // Key buffer: start position and the displayed value, saturated to four digits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (in_take && key_known)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && key_known)
        begin
            pend_start_reg <= (key == ksld_pkg::KEY_SHOW) ? ksld_pkg::IDX_LABEL_CMD
                                                          : ksld_pkg::IDX_VALUE_CMD;
            pend_value_reg <= (setpoint_next > ksld_pkg::DISPLAY_MAX) ? ksld_pkg::DISPLAY_MAX
                                                                      : setpoint_next;
        end
    end

    // Emitter position and remaining value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else if (load)
        begin
            act_reg <= 1'b1;
        end
        else if (fin)
        begin
            act_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_reg <= pend_start_reg;
            rem_reg <= pend_value_reg;
        end
        else if (step)
        begin
            idx_reg <= idx_reg + 5'd1;
            rem_reg <= gen_rem_next;
        end
    end

    ksld_byte_gen u_byte_gen (
        .idx      (idx_reg),
        .rem      (rem_reg),
        .beat     (beat),
        .rem_next (gen_rem_next)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (step)
        begin
            m_tvalid <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_tdata <= beat.lcd_byte;
            m_tuser <= beat.is_data;
            m_tlast <= beat.last_byte;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ksld_checker.sv
// Port checker for the setpoint LCD block, bound to the top level.
`default_nettype none
module ksld_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire       m_tuser,
    input wire       m_tlast
);

    // A stalled beat stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // Every sequence ends on a value digit.
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser && m_tdata >= ksld_pkg::ASCII_ZERO
                                && m_tdata <= ksld_pkg::ASCII_ZERO + 8'd9)
        else $error("sequence ends on a byte that is not a digit");

    // Command beats are only cursor addresses.
    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == ksld_pkg::CMD_LABEL
                                 || m_tdata == ksld_pkg::CMD_UNIT
                                 || m_tdata == ksld_pkg::CMD_VALUE)
        else $error("unexpected command byte");

    // The value address is followed at once by a digit.
    a_value_follow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tuser && m_tdata == ksld_pkg::CMD_VALUE
        |=> m_tvalid && m_tuser)
        else $error("value address not followed by a digit");

endmodule

bind key_setpoint_lcd_display ksld_checker u_ksld_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the key setpoint LCD block with a byte-level scoreboard.
module tb;

    typedef logic [ksld_pkg::KEY_W-1:0] key_t;

    localparam int STALL_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RANDOM_PHASES  = 12;
    localparam int KEYS_PER_PHASE = 33;
    localparam int VAL_MAX        = (1 << ksld_pkg::VAL_W) - 1;

    // Key patterns that the block must ignore.
    localparam key_t KEY_ALL_PRESSED  = 4'h0;
    localparam key_t KEY_NONE_PRESSED = 4'hF;
    localparam key_t KEY_CHORD        = 4'h5;

    // Register indexes that map to no register.
    localparam logic [ksld_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [ksld_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    // Tracks the setpoint and limits and holds the LCD bytes still to arrive.
    class lcd_scoreboard;
        localparam int REPORT_MAX = 10;

        ksld_pkg::value_t upper_limit;
        ksld_pkg::value_t lower_limit;
        ksld_pkg::value_t setpoint;
        ksld_pkg::beat_t  expected_bytes[$];
        int               errors;

        function new();
            upper_limit = ksld_pkg::UPPER_LIMIT_RST;
            lower_limit = ksld_pkg::LOWER_LIMIT_RST;
            setpoint    = '0;
            errors      = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_MAX)
                $display("%t: %s", $time, msg);
        endfunction

        function void set_limit(logic [ksld_pkg::CFG_IDX_W-1:0] idx, ksld_pkg::value_t data);
            if (idx == ksld_pkg::REG_UPPER_LIMIT)
                upper_limit = data;
            else if (idx == ksld_pkg::REG_LOWER_LIMIT)
                lower_limit = data;
        endfunction

        function void queue_byte(ksld_pkg::lcd_byte_t b, logic is_data, logic last);
            ksld_pkg::beat_t e;
            e.lcd_byte  = b;
            e.is_data   = is_data;
            e.last_byte = last;
            expected_bytes.push_back(e);
        endfunction

        // Updates the setpoint for one accepted key and queues the bytes it causes.
        function void apply_key(key_t key);
            string label_text = "SET SPD:";
            string unit_text  = "rpm";
            int shown;
            int i;
            case (key)
                ksld_pkg::KEY_SHOW:
                begin
                    queue_byte(ksld_pkg::CMD_LABEL, 1'b0, 1'b0);
                    for (i = 0; i < label_text.len(); i++)
                        queue_byte(label_text[i], 1'b1, 1'b0);
                    queue_byte(ksld_pkg::CMD_UNIT, 1'b0, 1'b0);
                    for (i = 0; i < unit_text.len(); i++)
                        queue_byte(unit_text[i], 1'b1, 1'b0);
                end
                ksld_pkg::KEY_UP:
                    setpoint = (setpoint >= upper_limit) ? upper_limit : setpoint + 1'b1;
                ksld_pkg::KEY_DOWN:
                    setpoint = (setpoint <= lower_limit) ? lower_limit : setpoint - 1'b1;
                ksld_pkg::KEY_CLEAR:
                    setpoint = '0;
                default:
                    return;
            endcase

            // The value rewrite closes every sequence; the display saturates at 9999.
            shown = (setpoint > ksld_pkg::DISPLAY_MAX) ? ksld_pkg::DISPLAY_MAX : setpoint;
            queue_byte(ksld_pkg::CMD_VALUE, 1'b0, 1'b0);
            queue_byte(ksld_pkg::lcd_byte_t'(ksld_pkg::ASCII_ZERO + shown / 1000),
                       1'b1, 1'b0);
            queue_byte(ksld_pkg::lcd_byte_t'(ksld_pkg::ASCII_ZERO + (shown / 100) % 10),
                       1'b1, 1'b0);
            queue_byte(ksld_pkg::lcd_byte_t'(ksld_pkg::ASCII_ZERO + (shown / 10) % 10),
                       1'b1, 1'b0);
            queue_byte(ksld_pkg::lcd_byte_t'(ksld_pkg::ASCII_ZERO + shown % 10),
                       1'b1, 1'b1);
        endfunction

        // Compares one output beat with the oldest expected byte.
        function void check_byte(ksld_pkg::lcd_byte_t b, logic is_data, logic last);
            ksld_pkg::beat_t e;
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("unexpected beat: byte %02h data %0b last %0b",
                                 b, is_data, last));
                return;
            end
            e = expected_bytes.pop_front();
            if (b !== e.lcd_byte || is_data !== e.is_data || last !== e.last_byte)
                report($sformatf({"mismatch: expected byte %02h data %0b last %0b, ",
                                  "got byte %02h data %0b last %0b"},
                                 e.lcd_byte, e.is_data, e.last_byte, b, is_data, last));
        endfunction
    endclass

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           wr_en    = 1'b0;
    logic [ksld_pkg::CFG_IDX_W-1:0] wr_index = '0;
    ksld_pkg::value_t               wr_data  = '0;
    logic                           s_tvalid = 1'b0;
    logic [7:0]                     s_tdata  = '0;
    logic                           m_tready = 1'b0;
    wire                            s_tready;
    wire                            m_tvalid;
    wire  [7:0]                     m_tdata;
    wire                            m_tuser;
    wire                            m_tlast;

    lcd_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;

    key_setpoint_lcd_display uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The receiver may stall at random on any cycle, with the chance set by recv_idle_pct.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Every accepted output beat is checked against the prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tuser, m_tlast);
    end

    // Watchdog: ends the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Offers one key beat, with a random gap first, and waits until it is taken.
    task automatic send_key(input key_t key);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(8 - ksld_pkg::KEY_W){1'b0}}, key};
        do
            @(posedge clk);
        while (!s_tready);
        sb.apply_key(key);
    endtask

    // Waits until every expected byte has arrived and the block has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ksld_pkg::CFG_IDX_W-1:0] idx,
                             input ksld_pkg::value_t data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        sb.set_limit(idx, data);
    endtask

    // Writes both limits once the block is idle, optionally hitting the unused indexes.
    task automatic program_limits(input ksld_pkg::value_t upper, input ksld_pkg::value_t lower,
                                  input bit spare);
        wait_idle();
        if (spare)
        begin
            write_reg(REG_UNUSED_2, ksld_pkg::value_t'($urandom));
            write_reg(REG_UNUSED_3, ksld_pkg::value_t'($urandom));
        end
        write_reg(ksld_pkg::REG_UPPER_LIMIT, upper);
        write_reg(ksld_pkg::REG_LOWER_LIMIT, lower);
        wr_en <= 1'b0;
    endtask

    // Limits are often placed near the setpoint so that both clamps are hit.
    function automatic ksld_pkg::value_t pick_limit();
        int near;
        near = int'(sb.setpoint) + int'($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ksld_pkg::value_t'(1);
            2:       return ksld_pkg::DISPLAY_MAX;
            3:       return ksld_pkg::value_t'($urandom_range(ksld_pkg::DISPLAY_MAX + 1,
                                                             VAL_MAX));
            4:       return ksld_pkg::value_t'(VAL_MAX);
            5, 6, 7: return ksld_pkg::value_t'((near < 0) ? 0
                                               : ((near > VAL_MAX) ? VAL_MAX : near));
            default: return ksld_pkg::value_t'($urandom_range(0, VAL_MAX));
        endcase
    endfunction

    // Mostly operation keys, with some arbitrary patterns mixed in.
    function automatic key_t pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return ksld_pkg::KEY_SHOW;
        else if (r < 45)
            return ksld_pkg::KEY_UP;
        else if (r < 75)
            return ksld_pkg::KEY_DOWN;
        else if (r < 85)
            return ksld_pkg::KEY_CLEAR;
        return key_t'($urandom_range(0, 15));
    endfunction

    initial
    begin
        int   phase;
        int   live;
        key_t key;

        sb = new();
        send_idle_pct = 16;
        recv_idle_pct = 56;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limits: redraw, both directions, clamp at the lower limit, no wrap
        // below zero, and patterns that must be ignored.
        send_key(ksld_pkg::KEY_SHOW);
        send_key(ksld_pkg::KEY_UP);
        send_key(ksld_pkg::KEY_UP);
        send_key(ksld_pkg::KEY_DOWN);
        send_key(ksld_pkg::KEY_DOWN);
        send_key(ksld_pkg::KEY_DOWN);
        send_key(ksld_pkg::KEY_CLEAR);
        send_key(ksld_pkg::KEY_DOWN);
        send_key(KEY_ALL_PRESSED);
        send_key(KEY_NONE_PRESSED);
        send_key(KEY_CHORD);

        // Full-scale limits push the setpoint past 9999, so the display saturates.
        program_limits(ksld_pkg::value_t'(VAL_MAX), ksld_pkg::value_t'(VAL_MAX), 1'b1);
        send_key(ksld_pkg::KEY_DOWN);
        send_key(ksld_pkg::KEY_SHOW);
        send_key(ksld_pkg::KEY_UP);

        // Zero limits: up clamps down to zero, down stays at zero.
        program_limits('0, '0, 1'b0);
        send_key(ksld_pkg::KEY_UP);
        send_key(ksld_pkg::KEY_DOWN);

        // Crossed limits: each key follows its own rule.
        program_limits(ksld_pkg::value_t'(1), ksld_pkg::DISPLAY_MAX, 1'b0);
        send_key(ksld_pkg::KEY_UP);
        send_key(ksld_pkg::KEY_UP);
        send_key(ksld_pkg::KEY_DOWN);

        // Setpoint above the upper limit, then clear and a down key at a zero lower limit.
        program_limits(ksld_pkg::DISPLAY_MAX - 1'b1, '0, 1'b0);
        send_key(ksld_pkg::KEY_UP);
        send_key(ksld_pkg::KEY_DOWN);
        send_key(ksld_pkg::KEY_CLEAR);
        send_key(ksld_pkg::KEY_DOWN);

        // Random phases, each with fresh limits; the idle pattern changes by thirds.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == RANDOM_PHASES / 3)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 16;
            end
            else if (phase == 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            program_limits(pick_limit(), pick_limit(), $urandom_range(0, 3) == 0);
            live = 0;
            while (live < KEYS_PER_PHASE)
            begin
                key = pick_key();
                send_key(key);
                if (key == ksld_pkg::KEY_SHOW || key == ksld_pkg::KEY_UP
                    || key == ksld_pkg::KEY_DOWN || key == ksld_pkg::KEY_CLEAR)
                    live++;
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.expected_bytes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ksld_pkg.sv
rtl/ksld_byte_gen.sv
rtl/key_setpoint_lcd_display.sv
rtl/ksld_checker.sv
tb/sv/tb.sv
